// ----- src/owbm_pkg.sv -----
// Package: shared types and constants for the one-wire bus master.
package owbm_pkg;

  localparam int CntW    = 12;  // phase tick counter width
  localparam int RegW    = 12;  // width of each timing register
  localparam int NumRegs = 8;
  localparam int IdxW    = 3;   // configuration index width
  localparam int ByteW   = 8;

  typedef logic [NumRegs-1:0][RegW-1:0] cfg_array_t;

  // register indexes
  localparam logic [IdxW-1:0] REG_RESET_IDLE    = 3'd0;
  localparam logic [IdxW-1:0] REG_RESET_LOW     = 3'd1;
  localparam logic [IdxW-1:0] REG_PRESENCE_WAIT = 3'd2;
  localparam logic [IdxW-1:0] REG_PRESENCE_TAIL = 3'd3;
  localparam logic [IdxW-1:0] REG_SLOT_LOW      = 3'd4;
  localparam logic [IdxW-1:0] REG_WRITE_HOLD    = 3'd5;
  localparam logic [IdxW-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [IdxW-1:0] REG_READ_TAIL     = 3'd7;

  localparam cfg_array_t CFG_DEFAULTS = '{
    7: 12'd60, 6: 12'd6, 5: 12'd60, 4: 12'd4,
    3: 12'd430, 2: 12'd80, 1: 12'd750, 0: 12'd500
  };

  // operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_RST_IDLE = 11'b000_0000_0010,
    PH_RST_LOW  = 11'b000_0000_0100,
    PH_RST_WAIT = 11'b000_0000_1000,
    PH_RST_TAIL = 11'b000_0001_0000,
    PH_W_LOW    = 11'b000_0010_0000,
    PH_W_HOLD   = 11'b000_0100_0000,
    PH_W_REC    = 11'b000_1000_0000,
    PH_R_LOW    = 11'b001_0000_0000,
    PH_R_WAIT   = 11'b010_0000_0000,
    PH_R_TAIL   = 11'b100_0000_0000
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic             rejected;
    logic             no_presence;
    logic [ByteW-1:0] read_byte;
    logic             done_res;
    logic             busy_res;
    logic             line_low;
  } result_t;

endpackage

// ----- src/one_wire_bus_master.sv -----
// One-wire bus master top level: stream ports, config port, result register.
//
// Each input transaction is one microsecond tick of the bus. It carries the
// operation (tick only, reset-and-presence, write byte, read byte), the byte
// to write and the line level sampled this tick; every input transaction
// yields exactly one result transaction with the line drive for the tick and
// the status flags. The block takes one transaction per clock cycle; its
// result appears in the output register on the next cycle. The only thing
// that holds in_tready low is a full output register that downstream is not
// taking, so with out_tready high the rate is one tick per cycle. Timing
// registers (indexes 0..7: reset idle, reset low, presence wait, presence
// tail, slot low, write hold, read sample, read tail) are written through
// the cfg channel, which is always ready; write them only while the master
// is idle. A duration of zero acts as one tick. Bytes go LSB first.
module one_wire_bus_master (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,   // [7:0] data_byte, [8] line_sample
  input  logic [1:0]                in_tuser,   // [1:0] operation
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [0] line_low, [1] busy_res, [2] done_res, [10:3] read_byte,
  // [11] no_presence, [12] rejected
  output logic [15:0]               out_tdata,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [owbm_pkg::IdxW-1:0] cfg_index,
  input  logic [owbm_pkg::RegW-1:0] cfg_data
);

  owbm_pkg::cfg_array_t regs;
  owbm_pkg::result_t    res;
  owbm_pkg::result_t    res_r;
  logic                 out_valid_r;
  logic                 in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  owbm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  owbm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_acc),
    .operation   (owbm_pkg::op_t'(in_tuser)),
    .data_byte   (in_tdata[7:0]),
    .line_sample (in_tdata[8]),
    .regs        (regs),
    .res         (res)
  );

  // result register: loads on every accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r};

  // an accepted tick always lands in the result register
  a_acc_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction did not produce a result");

  // a completing sequence never reports busy on the same tick
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res.done_res |-> !res.busy_res)
    else $error("done and busy together");

  // only a real start can be rejected
  a_rej_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res.rejected |-> in_tuser != owbm_pkg::OP_TICK)
    else $error("tick-only transaction flagged as rejected");

  // a byte write or read start taken while idle leaves the master busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == owbm_pkg::OP_WRITE || in_tuser == owbm_pkg::OP_READ)
      && !res.rejected |-> res.busy_res)
    else $error("byte transfer start did not go busy");

endmodule

// ----- src/owbm_cfg_regs.sv -----
// Timing register file written through the configuration channel.
module owbm_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [owbm_pkg::IdxW-1:0] wr_index,
  input  logic [owbm_pkg::RegW-1:0] wr_data,
  output owbm_pkg::cfg_array_t      regs
);

  owbm_pkg::cfg_array_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= owbm_pkg::CFG_DEFAULTS;
    end else if (wr_en) begin
      regs_r[wr_index] <= wr_data;
    end
  end

  assign regs = regs_r;

endmodule

// ----- src/owbm_seq.sv -----
// Bus sequencer: phase state, tick counter, bit shifter and per-tick result.
module owbm_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  owbm_pkg::op_t              operation,
  input  logic [owbm_pkg::ByteW-1:0] data_byte,
  input  logic                       line_sample,
  input  owbm_pkg::cfg_array_t       regs,
  output owbm_pkg::result_t          res
);

  owbm_pkg::phase_t             phase_r, phase_nxt, phase_eff;
  logic [owbm_pkg::CntW-1:0]    tick_r, tick_nxt, tick_eff;
  logic [2:0]                   bit_r, bit_nxt, bit_eff;
  logic [owbm_pkg::ByteW-1:0]   shift_r, shift_nxt, shift_eff;
  logic [owbm_pkg::ByteW-1:0]   rx_r, rx_nxt;
  logic                         perr_r, perr_nxt, perr_eff;
  logic [owbm_pkg::RegW-1:0]    dur;
  logic [owbm_pkg::CntW:0]      tick_inc;
  logic                         tdone;
  logic                         line, done, rej;
  logic                         last_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owbm_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      rx_r    <= '0;
      perr_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
      perr_r  <= perr_nxt;
    end
  end

  // start handling: a start taken in idle also runs the first tick
  always_comb begin
    phase_eff = phase_r;
    tick_eff  = tick_r;
    bit_eff   = bit_r;
    shift_eff = shift_r;
    perr_eff  = perr_r;
    rej       = 1'b0;
    if (operation != owbm_pkg::OP_TICK) begin
      if (phase_r != owbm_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_eff = '0;
        bit_eff  = '0;
        unique case (operation)
          owbm_pkg::OP_RESET: begin
            perr_eff  = 1'b0;
            phase_eff = owbm_pkg::PH_RST_IDLE;
          end
          owbm_pkg::OP_WRITE: begin
            shift_eff = data_byte;
            phase_eff = owbm_pkg::PH_W_LOW;
          end
          default: begin
            shift_eff = '0;
            phase_eff = owbm_pkg::PH_R_LOW;
          end
        endcase
      end
    end
  end

  // duration of the running phase
  always_comb begin
    unique case (phase_eff)
      owbm_pkg::PH_RST_IDLE: dur = regs[owbm_pkg::REG_RESET_IDLE];
      owbm_pkg::PH_RST_LOW:  dur = regs[owbm_pkg::REG_RESET_LOW];
      owbm_pkg::PH_RST_WAIT: dur = regs[owbm_pkg::REG_PRESENCE_WAIT];
      owbm_pkg::PH_RST_TAIL: dur = regs[owbm_pkg::REG_PRESENCE_TAIL];
      owbm_pkg::PH_W_LOW,
      owbm_pkg::PH_R_LOW:    dur = regs[owbm_pkg::REG_SLOT_LOW];
      owbm_pkg::PH_W_HOLD:   dur = regs[owbm_pkg::REG_WRITE_HOLD];
      owbm_pkg::PH_R_WAIT:   dur = regs[owbm_pkg::REG_READ_SAMPLE];
      owbm_pkg::PH_R_TAIL:   dur = regs[owbm_pkg::REG_READ_TAIL];
      default:               dur = '0;
    endcase
  end

  // zero acts as one tick; a full counter always wraps since dur fits
  assign tick_inc = {1'b0, tick_eff} + {{owbm_pkg::CntW{1'b0}}, 1'b1};
  assign tdone    = tick_inc >= {{(owbm_pkg::CntW + 1 - owbm_pkg::RegW){1'b0}}, dur};
  assign last_bit = (bit_eff == 3'd7);

  always_comb begin
    phase_nxt = phase_eff;
    tick_nxt  = tdone ? '0 : tick_inc[owbm_pkg::CntW-1:0];
    bit_nxt   = bit_eff;
    shift_nxt = shift_eff;
    rx_nxt    = rx_r;
    perr_nxt  = perr_eff;
    line      = 1'b0;
    done      = 1'b0;
    unique case (phase_eff)
      owbm_pkg::PH_IDLE: begin
        tick_nxt = tick_eff;
      end
      owbm_pkg::PH_RST_IDLE: begin
        if (tdone) phase_nxt = owbm_pkg::PH_RST_LOW;
      end
      owbm_pkg::PH_RST_LOW: begin
        line = 1'b1;
        if (tdone) phase_nxt = owbm_pkg::PH_RST_WAIT;
      end
      owbm_pkg::PH_RST_WAIT: begin
        if (tdone) begin
          if (!line_sample) begin
            phase_nxt = owbm_pkg::PH_RST_TAIL;
          end else begin
            perr_nxt  = 1'b1;
            phase_nxt = owbm_pkg::PH_IDLE;
            done      = 1'b1;
          end
        end
      end
      owbm_pkg::PH_RST_TAIL: begin
        if (tdone) begin
          phase_nxt = owbm_pkg::PH_IDLE;
          done      = 1'b1;
        end
      end
      owbm_pkg::PH_W_LOW: begin
        line = 1'b1;
        if (tdone) phase_nxt = owbm_pkg::PH_W_HOLD;
      end
      owbm_pkg::PH_W_HOLD: begin
        line = ~shift_eff[0];
        if (tdone) phase_nxt = owbm_pkg::PH_W_REC;
      end
      owbm_pkg::PH_W_REC: begin
        // one released recovery tick, then next bit
        shift_nxt = {1'b0, shift_eff[owbm_pkg::ByteW-1:1]};
        tick_nxt  = '0;
        if (last_bit) begin
          phase_nxt = owbm_pkg::PH_IDLE;
          done      = 1'b1;
        end else begin
          bit_nxt   = bit_eff + 3'd1;
          phase_nxt = owbm_pkg::PH_W_LOW;
        end
      end
      owbm_pkg::PH_R_LOW: begin
        line = 1'b1;
        if (tdone) phase_nxt = owbm_pkg::PH_R_WAIT;
      end
      owbm_pkg::PH_R_WAIT: begin
        if (tdone) begin
          shift_nxt = {line_sample, shift_eff[owbm_pkg::ByteW-1:1]};
          phase_nxt = owbm_pkg::PH_R_TAIL;
        end
      end
      owbm_pkg::PH_R_TAIL: begin
        if (tdone) begin
          if (last_bit) begin
            rx_nxt    = shift_eff;
            phase_nxt = owbm_pkg::PH_IDLE;
            done      = 1'b1;
          end else begin
            bit_nxt   = bit_eff + 3'd1;
            phase_nxt = owbm_pkg::PH_R_LOW;
          end
        end
      end
      default: begin
        phase_nxt = owbm_pkg::PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    res.line_low    = line;
    res.busy_res    = (phase_nxt != owbm_pkg::PH_IDLE);
    res.done_res    = done;
    res.read_byte   = rx_nxt;
    res.no_presence = perr_nxt;
    res.rejected    = rej;
  end

endmodule

// ----- tb/one_wire_bus_master_tb.sv -----
// Testbench for the one-wire bus master: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps

module one_wire_bus_master_tb;

  localparam int CntW    = owbm_pkg::CntW;
  localparam int RegW    = owbm_pkg::RegW;
  localparam int IdxW    = owbm_pkg::IdxW;
  localparam int ByteW   = owbm_pkg::ByteW;
  localparam int NumRegs = owbm_pkg::NumRegs;
  localparam int LastBit = ByteW - 1;  // bit index of the final slot in a byte

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [15:0]     in_tdata = '0;      // [7:0] data_byte, [8] line_sample
  logic [1:0]      in_tuser = '0;      // [1:0] operation
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [15:0]     out_tdata;          // [0] line_low .. [12] rejected, see result_t
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data = '0;

  one_wire_bus_master dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous wall; a full run with the heaviest stall mix stays far below it.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Bus master model: own copy of the timing registers and sequencer state.
  // ---------------------------------------------------------------------------
  owbm_pkg::cfg_array_t m_regs;
  owbm_pkg::phase_t     m_phase;
  logic [CntW-1:0]      m_cnt;
  logic [2:0]           m_bit;
  logic [ByteW-1:0]     m_shift;
  logic [ByteW-1:0]     m_rxbyte;
  logic                 m_perr;

  owbm_pkg::result_t bus_results_q [$];   // expected result transactions, oldest first

  int n_ticks = 0;
  int n_starts [4] = '{0, 0, 0, 0};
  int n_refused = 0;
  int n_no_presence = 0;
  int n_bad = 0;

  int gap_pct = 0;     // sender idle chance per cycle, percent
  int stall_pct = 0;   // receiver stall chance per cycle, percent

  // Advances the phase counter; true on the last tick of a phase.
  // A zero duration ends after one tick, the counter wraps at its full value.
  function automatic bit slot_over(logic [RegW-1:0] dur);
    logic [CntW:0] nxt;
    nxt = {1'b0, m_cnt} + 1'b1;
    if (nxt >= dur || m_cnt == '1) begin
      m_cnt = '0;
      return 1'b1;
    end
    m_cnt = nxt[CntW-1:0];
    return 1'b0;
  endfunction

  // One microsecond tick of the master: line drive and status for this tick.
  function automatic owbm_pkg::result_t bus_tick(owbm_pkg::op_t op, logic [ByteW-1:0] data,
                                                 logic smp);
    owbm_pkg::result_t r;
    r = '0;
    if (op != owbm_pkg::OP_TICK) begin
      if (m_phase != owbm_pkg::PH_IDLE) begin
        r.rejected = 1'b1;   // busy: start is dropped, nothing else changes
        n_refused++;
      end else begin
        n_starts[int'(op)]++;
        m_cnt = '0;
        m_bit = '0;
        unique case (op)
          owbm_pkg::OP_RESET: begin
            m_perr  = 1'b0;
            m_phase = owbm_pkg::PH_RST_IDLE;
          end
          owbm_pkg::OP_WRITE: begin
            m_shift = data;
            m_phase = owbm_pkg::PH_W_LOW;
          end
          owbm_pkg::OP_READ: begin
            m_shift = '0;
            m_phase = owbm_pkg::PH_R_LOW;
          end
          default: ;
        endcase
      end
    end
    // the start tick already runs the first tick of its sequence
    unique case (m_phase)
      owbm_pkg::PH_RST_IDLE:
        if (slot_over(m_regs[owbm_pkg::REG_RESET_IDLE])) m_phase = owbm_pkg::PH_RST_LOW;
      owbm_pkg::PH_RST_LOW: begin
        r.line_low = 1'b1;
        if (slot_over(m_regs[owbm_pkg::REG_RESET_LOW])) m_phase = owbm_pkg::PH_RST_WAIT;
      end
      owbm_pkg::PH_RST_WAIT: if (slot_over(m_regs[owbm_pkg::REG_PRESENCE_WAIT])) begin
        if (!smp) begin
          m_phase = owbm_pkg::PH_RST_TAIL;
        end else begin
          // nobody answered: finish right away with the error flag
          m_perr     = 1'b1;
          m_phase    = owbm_pkg::PH_IDLE;
          r.done_res = 1'b1;
          n_no_presence++;
        end
      end
      owbm_pkg::PH_RST_TAIL: if (slot_over(m_regs[owbm_pkg::REG_PRESENCE_TAIL])) begin
        m_phase    = owbm_pkg::PH_IDLE;
        r.done_res = 1'b1;
      end
      owbm_pkg::PH_W_LOW: begin
        r.line_low = 1'b1;
        if (slot_over(m_regs[owbm_pkg::REG_SLOT_LOW])) m_phase = owbm_pkg::PH_W_HOLD;
      end
      owbm_pkg::PH_W_HOLD: begin
        r.line_low = ~m_shift[0];
        if (slot_over(m_regs[owbm_pkg::REG_WRITE_HOLD])) m_phase = owbm_pkg::PH_W_REC;
      end
      owbm_pkg::PH_W_REC: begin
        // single released recovery tick, then next bit
        m_shift = m_shift >> 1;
        m_cnt   = '0;
        if (m_bit == LastBit) begin
          m_phase    = owbm_pkg::PH_IDLE;
          r.done_res = 1'b1;
        end else begin
          m_bit   = m_bit + 1'b1;
          m_phase = owbm_pkg::PH_W_LOW;
        end
      end
      owbm_pkg::PH_R_LOW: begin
        r.line_low = 1'b1;
        if (slot_over(m_regs[owbm_pkg::REG_SLOT_LOW])) m_phase = owbm_pkg::PH_R_WAIT;
      end
      owbm_pkg::PH_R_WAIT: if (slot_over(m_regs[owbm_pkg::REG_READ_SAMPLE])) begin
        m_shift = {smp, m_shift[ByteW-1:1]};   // LSB first
        m_phase = owbm_pkg::PH_R_TAIL;
      end
      owbm_pkg::PH_R_TAIL: if (slot_over(m_regs[owbm_pkg::REG_READ_TAIL])) begin
        if (m_bit == LastBit) begin
          m_rxbyte   = m_shift;
          m_phase    = owbm_pkg::PH_IDLE;
          r.done_res = 1'b1;
        end else begin
          m_bit   = m_bit + 1'b1;
          m_phase = owbm_pkg::PH_R_LOW;
        end
      end
      default: ;
    endcase
    r.busy_res    = (m_phase != owbm_pkg::PH_IDLE);
    r.read_byte   = m_rxbyte;
    r.no_presence = m_perr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Drive one tick transaction; the model steps when the handshake completes.
  // A typed expectation, where given, replaces the model's answer in the queue.
  task automatic send_tick(input owbm_pkg::op_t op, input logic [ByteW-1:0] data,
                           input logic smp, input bit use_want = 1'b0,
                           input owbm_pkg::result_t want = '0);
    owbm_pkg::result_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, smp, data};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = bus_tick(op, data, smp);
    bus_results_q.push_back(use_want ? want : r);
    n_ticks++;
  endtask

  // Plain ticks until the running sequence ends; smp < 0 means a random line level.
  task automatic tick_until_idle(input int smp);
    logic s;
    while (m_phase != owbm_pkg::PH_IDLE) begin
      s = (smp < 0) ? 1'($urandom_range(1)) : smp[0];
      send_tick(owbm_pkg::OP_TICK, 8'($urandom), s);
    end
  endtask

  // Sender holds off until every expected transaction is back.
  task automatic hold_off();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (bus_results_q.size() != 0);
  endtask

  // Timing registers change only with the master idle and the pipe empty.
  task automatic load_timing(input owbm_pkg::cfg_array_t v);
    tick_until_idle(-1);
    hold_off();
    repeat (2) @(posedge clk);   // result register latency
    for (int i = 0; i < NumRegs; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= IdxW'(i);
      cfg_data  <= v[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      m_regs[i] = v[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows flagged known carry a hand-typed expectation
  // {rejected, no_presence, read_byte, done, busy, line_low}; the others go to
  // the model. A hold row keeps ticking at its line level until idle.
  // ---------------------------------------------------------------------------
  typedef struct {
    owbm_pkg::op_t     op;
    logic [ByteW-1:0]  data;
    logic              smp;
    bit                hold;
    bit                min_timing;   // load all-zero timing before this row
    bit                known;
    owbm_pkg::result_t want;
  } dir_row_t;

  dir_row_t dir_rows [0:16] = '{
    // after reset, default timing
    '{owbm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{owbm_pkg::OP_WRITE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}},
    '{owbm_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}},
    '{owbm_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1}},
    // zero durations from here on: each phase is one tick
    '{owbm_pkg::OP_RESET, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, '0},   // no presence pulse
    '{owbm_pkg::OP_TICK,  8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{owbm_pkg::OP_RESET, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},   // presence seen, flag clears
    '{owbm_pkg::OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{owbm_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, '0},
    '{owbm_pkg::OP_WRITE, 8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{owbm_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, 1'b0, '0},   // reads back all ones
    '{owbm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b0}},
    '{owbm_pkg::OP_READ,  8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, '0},   // all zeros
    '{owbm_pkg::OP_WRITE, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{owbm_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0},   // refused mid-write
    '{owbm_pkg::OP_RESET, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{owbm_pkg::OP_RESET, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, '0}    // refused mid-reset
  };

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, in-order compare against the queue.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    owbm_pkg::result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = owbm_pkg::result_t'(out_tdata[12:0]);
      if (bus_results_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("%0t: unexpected result transaction %h", $realtime, got);
      end else begin
        want = bus_results_q.pop_front();
        if (got.line_low !== want.line_low || got.busy_res !== want.busy_res ||
            got.done_res !== want.done_res || got.read_byte !== want.read_byte ||
            got.no_presence !== want.no_presence || got.rejected !== want.rejected) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: mismatch exp line=%b busy=%b done=%b rd=%h np=%b rej=%b",
                     $realtime, want.line_low, want.busy_res, want.done_res,
                     want.read_byte, want.no_presence, want.rejected,
                     "  got line=%b busy=%b done=%b rd=%h np=%b rej=%b",
                     got.line_low, got.busy_res, got.done_res,
                     got.read_byte, got.no_presence, got.rejected);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    owbm_pkg::cfg_array_t v;
    owbm_pkg::op_t        op;
    int                   idle_mix [4][2];
    idle_mix = '{'{0, 0}, '{64, 0}, '{0, 64}, '{27, 27}};   // {sender, receiver}

    m_regs   = owbm_pkg::CFG_DEFAULTS;
    m_phase  = owbm_pkg::PH_IDLE;
    m_cnt    = '0;
    m_bit    = '0;
    m_shift  = '0;
    m_rxbyte = '0;
    m_perr   = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: default timing first, then all-zero timing
    for (int i = 0; i < 17; i++) begin
      if (dir_rows[i].min_timing) load_timing('0);
      send_tick(dir_rows[i].op, dir_rows[i].data, dir_rows[i].smp,
                dir_rows[i].known, dir_rows[i].want);
      if (dir_rows[i].hold) tick_until_idle(int'(dir_rows[i].smp));
    end

    // random part: two timing sets per idling pattern, short durations mostly
    for (int rnd = 0; rnd < 8; rnd++) begin
      for (int i = 0; i < NumRegs; i++)
        v[i] = ($urandom_range(7) == 0) ? RegW'($urandom_range(40)) : RegW'($urandom_range(3));
      load_timing(v);
      gap_pct   = idle_mix[rnd / 2][0];
      stall_pct = idle_mix[rnd / 2][1];
      for (int k = 0; k < 170; k++) begin
        if ($urandom_range(149) == 0) hold_off();
        if (m_phase == owbm_pkg::PH_IDLE)
          op = ($urandom_range(99) < 65) ? owbm_pkg::op_t'($urandom_range(1, 3))
                                         : owbm_pkg::OP_TICK;
        else
          op = ($urandom_range(99) < 8) ? owbm_pkg::op_t'($urandom_range(1, 3))
                                        : owbm_pkg::OP_TICK;
        send_tick(op, 8'($urandom), 1'($urandom_range(1)));
      end
    end

    tick_until_idle(-1);
    hold_off();
    repeat (4) @(posedge clk);

    if (bus_results_q.size() != 0) begin
      n_bad += bus_results_q.size();
      $display("%0d expected result transactions never arrived", bus_results_q.size());
    end

    $display("Ran %0d bus ticks: %0d resets (%0d without presence), %0d byte writes, %0d reads.",
             n_ticks, n_starts[int'(owbm_pkg::OP_RESET)], n_no_presence,
             n_starts[int'(owbm_pkg::OP_WRITE)], n_starts[int'(owbm_pkg::OP_READ)]);
    $display("%0d starts refused while busy; default, all-zero and short timings, four stall mixes.",
             n_refused);
    if (n_bad == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", n_bad);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
